### hw/rtl/mcrt_pkg.sv
// Shared types, codes and helpers for the multicast address refcount table.
// No dependencies; every other file of the block imports this package.
package mcrt_pkg;

	localparam int ADDR_W     = 64;
	localparam int REFS_W     = 16;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	// request kinds; any other code is a lookup
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_UNSUP = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [1:0] EVENT_NONE    = 2'd0;
	localparam logic [1:0] EVENT_ENABLE  = 2'd1;
	localparam logic [1:0] EVENT_DISABLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MC_EN      = 2'd1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        client;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [1:0]        filter_event;
		logic [ADDR_W-1:0] filter_address;
		logic              lookup_active;
		logic [CNT_W-1:0]  active_count;
		logic [CNT_W-1:0]  client_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [REFS_W-1:0] refs;
	} ent_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// byte mask for the compared part of an address; 0 acts as 1, above 8 as 8
	function automatic logic [ADDR_W-1:0] addr_mask(input logic [3:0] nbytes);
		logic [3:0]        n;
		logic [ADDR_W-1:0] m;
		n = (nbytes == 4'd0) ? 4'd1 : nbytes;
		for (int b = 0; b < ADDR_W / 8; b++)
			m[b*8 +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
		return m;
	endfunction

endpackage

### hw/rtl/mcrt_entry_ram.sv
// Entry table memory: stored address and reference count per position.
// One write port, one read port with registered read data. Uses mcrt_pkg.
module mcrt_entry_ram
	import mcrt_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  ent_t             wdata,
	input  logic [IDX_W-1:0] raddr,
	output ent_t             rdata
);

	ent_t mem [DEPTH];
	ent_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/mcrt_client_ram.sv
// Per-client subscription bitmap and subscription count, one row per client.
// Valid flops make unwritten rows read as zero. Uses mcrt_pkg.
module mcrt_client_ram
	import mcrt_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4,
	parameter int BITS  = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [BITS-1:0]  wbits,
	input  logic [CNT_W-1:0] wcount,
	input  logic [IDX_W-1:0] raddr,
	output logic [BITS-1:0]  rbits,
	output logic [CNT_W-1:0] rcount
);

	logic [CNT_W+BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]      vld_q;
	logic [CNT_W+BITS-1:0] rdata_q;
	logic                  rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			rvld_q <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= {wcount, wbits};
		rdata_q <= mem[raddr];
	end

	assign rbits  = rvld_q ? rdata_q[BITS-1:0] : '0;
	assign rcount = rvld_q ? rdata_q[CNT_W+BITS-1:BITS] : '0;

endmodule

### hw/rtl/mcrt_ctrl.sv
// Sequencer: scans the entry RAM one position a cycle, then does the
// read-modify-write of entry, client row and counters. Uses mcrt_pkg.
module mcrt_ctrl
	import mcrt_pkg::*;
#(
	parameter int TABLE_DEPTH    = 64,
	parameter int CLIENTS        = 16,
	parameter int SUBSCRIBE_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp_data,
	input  logic [3:0]            addr_bytes,
	input  logic                  mc_en,
	output logic                  ent_we,
	output logic [$clog2(TABLE_DEPTH)-1:0] ent_waddr,
	output ent_t                  ent_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0] ent_raddr,
	input  ent_t                  ent_rdata,
	output logic                  cl_we,
	output logic [((CLIENTS < 16 ? CLIENTS : 16) > 1 ?
		$clog2(CLIENTS < 16 ? CLIENTS : 16) : 1)-1:0] cl_addr,
	output logic [SUBSCRIBE_BITS-1:0] cl_wbits,
	output logic [CNT_W-1:0]      cl_wcount,
	input  logic [SUBSCRIBE_BITS-1:0] cl_rbits,
	input  logic [CNT_W-1:0]      cl_rcount
);

	localparam int UW      = $clog2(TABLE_DEPTH + 1);
	localparam int PW      = $clog2(TABLE_DEPTH);
	localparam int CDEPTH  = (CLIENTS < 16) ? CLIENTS : 16;
	localparam int CIDX_W  = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int SB_W    = $clog2(SUBSCRIBE_BITS);
	localparam int PX_W    = ((PW > SB_W) ? PW : SB_W) + 1;

	state_t              state_q, state_d;
	logic                req_fire, issue, hit, commit;
	logic [1:0]          kind_q;
	logic [3:0]          client_q;
	logic [ADDR_W-1:0]   addr_q, mask_q, stored_q;
	logic [UW-1:0]       rd_idx_q, used_q, active_q, used_d, active_d;
	logic                cmp_vld_s1;
	logic [PW-1:0]       cmp_idx_s1, pos_q, pos_sel;
	logic                found_q;
	logic [REFS_W-1:0]   refs_q, base_refs;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                is_add, is_rem, client_ok, in_bitmap, table_full, upd_ent_we, upd_cl_we;
	logic [PX_W-1:0]     pos_x;
	logic [SUBSCRIBE_BITS-1:0] bit_sel;
	logic [1:0]          status, filter_event;
	logic                look;

	assign req_fire = req_valid && !req_stall;
	assign hit      = cmp_vld_s1 && ((ent_rdata.addr & mask_q) == addr_q);

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		issue     = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (hit)
					state_d = ST_UPDATE;
				else if (rd_idx_q < used_q)
					issue = 1'b1;
				else if (!cmp_vld_s1)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// update of the matched or appended entry
	always_comb begin
		is_add     = kind_q == KIND_ADD;
		is_rem     = kind_q == KIND_REMOVE;
		client_ok  = 32'(client_q) < CLIENTS;
		pos_sel    = found_q ? pos_q : used_q[PW-1:0];
		pos_x      = PX_W'(pos_sel);
		in_bitmap  = pos_x < PX_W'(SUBSCRIBE_BITS);
		bit_sel    = in_bitmap ? (SUBSCRIBE_BITS'(1) << pos_x[SB_W-1:0]) : '0;
		base_refs  = found_q ? refs_q : '0;
		table_full = !found_q && (used_q >= UW'(TABLE_DEPTH));

		status          = STATUS_OK;
		filter_event    = EVENT_NONE;
		look            = 1'b0;
		used_d          = used_q;
		active_d        = active_q;
		upd_ent_we      = 1'b0;
		ent_wdata.addr  = found_q ? stored_q : addr_q;
		ent_wdata.refs  = base_refs;
		upd_cl_we       = 1'b0;
		cl_wbits        = cl_rbits;
		cl_wcount       = cl_rcount;

		if (is_add || is_rem) begin
			if (!mc_en) begin
				status = STATUS_UNSUP;
			end else if (is_add) begin
				if (table_full) begin
					status = STATUS_FULL;
				end else begin
					upd_ent_we = 1'b1;
					if (!found_q)
						used_d = used_q + UW'(1);
					if (base_refs != REFS_MAX) begin
						ent_wdata.refs = base_refs + REFS_W'(1);
						if (base_refs == '0) begin
							active_d     = active_q + UW'(1);
							filter_event = EVENT_ENABLE;
						end
					end
					if (client_ok && in_bitmap) begin
						upd_cl_we = 1'b1;
						cl_wbits  = cl_rbits | bit_sel;
						if ((cl_rbits & bit_sel) == '0)
							cl_wcount = cl_rcount + CNT_W'(1);
					end
				end
			end else if (found_q && refs_q != '0) begin
				upd_ent_we     = 1'b1;
				ent_wdata.refs = refs_q - REFS_W'(1);
				if (refs_q == REFS_W'(1)) begin
					if (active_q != '0)
						active_d = active_q - UW'(1);
					filter_event = EVENT_DISABLE;
				end
				if (client_ok && in_bitmap) begin
					upd_cl_we = 1'b1;
					cl_wbits  = cl_rbits & ~bit_sel;
					if ((cl_rbits & bit_sel) != '0 && cl_rcount != '0)
						cl_wcount = cl_rcount - CNT_W'(1);
				end
			end
		end else begin
			look = found_q && refs_q != '0;
		end
	end

	assign ent_we    = commit && upd_ent_we;
	assign ent_waddr = pos_sel;
	assign ent_raddr = rd_idx_q[PW-1:0];
	assign cl_we     = commit && upd_cl_we;
	assign cl_addr   = client_q[CIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			active_q    <= '0;
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue;
			if (req_fire)
				rd_idx_q <= '0;
			else if (issue)
				rd_idx_q <= rd_idx_q + UW'(1);
			if (commit) begin
				used_q      <= used_d;
				active_q    <= active_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q   <= req_data.kind;
			client_q <= req_data.client;
			mask_q   <= addr_mask(addr_bytes);
			addr_q   <= req_data.address & addr_mask(addr_bytes);
			found_q  <= 1'b0;
		end
		if (issue)
			cmp_idx_s1 <= rd_idx_q[PW-1:0];
		if (state_q == ST_SCAN && hit) begin
			found_q  <= 1'b1;
			pos_q    <= cmp_idx_s1;
			refs_q   <= ent_rdata.refs;
			stored_q <= ent_rdata.addr;
		end
		if (commit) begin
			rsp_q.status         <= status;
			rsp_q.filter_event   <= filter_event;
			rsp_q.filter_address <= (filter_event != EVENT_NONE) ? addr_q : '0;
			rsp_q.lookup_active  <= look;
			rsp_q.active_count   <= CNT_W'(active_d);
			rsp_q.client_count   <= client_ok ? cl_wcount : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= used_q)
		else $error("more active addresses than entries");

	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		(ent_we || cl_we) |-> state_q == ST_UPDATE)
		else $error("table write outside update step");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (rsp_valid && state_q == ST_IDLE))
		else $error("committed item without result");

endmodule

### hw/rtl/multicast_address_refcount_table.sv
// After the request beat the scan reads stored addresses up to a match or the last entry,
// then the update commits and the result goes valid; a held result delays the update
// until it is taken. No new request is taken until the block is idle again, and the scan
// reads one stored address per cycle.
// Reset: counters, state and client bitmaps clear at once (valid flops), no sweep;
// config resets to 6 compared bytes with multicast enabled.
module multicast_address_refcount_table
	import mcrt_pkg::*;
#(
	parameter int TABLE_DEPTH    = 64,
	parameter int CLIENTS        = 16,
	parameter int SUBSCRIBE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW     = $clog2(TABLE_DEPTH);
	localparam int CDEPTH = (CLIENTS < 16) ? CLIENTS : 16;
	localparam int CIDX_W = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

	logic [3:0]                addr_bytes_q;
	logic                      mc_en_q;
	logic                      ent_we;
	logic [PW-1:0]             ent_waddr, ent_raddr;
	ent_t                      ent_wdata, ent_rdata;
	logic                      cl_we;
	logic [CIDX_W-1:0]         cl_addr;
	logic [SUBSCRIBE_BITS-1:0] cl_wbits, cl_rbits;
	logic [CNT_W-1:0]          cl_wcount, cl_rcount;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_bytes_q <= 4'd6;
			mc_en_q      <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ADDR_BYTES: addr_bytes_q <= cfg_data;
				CFG_MC_EN:      mc_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mcrt_ctrl #(
		.TABLE_DEPTH   (TABLE_DEPTH),
		.CLIENTS       (CLIENTS),
		.SUBSCRIBE_BITS(SUBSCRIBE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.addr_bytes(addr_bytes_q),
		.mc_en     (mc_en_q),
		.ent_we    (ent_we),
		.ent_waddr (ent_waddr),
		.ent_wdata (ent_wdata),
		.ent_raddr (ent_raddr),
		.ent_rdata (ent_rdata),
		.cl_we     (cl_we),
		.cl_addr   (cl_addr),
		.cl_wbits  (cl_wbits),
		.cl_wcount (cl_wcount),
		.cl_rbits  (cl_rbits),
		.cl_rcount (cl_rcount)
	);

	mcrt_entry_ram #(
		.DEPTH(TABLE_DEPTH),
		.IDX_W(PW)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.raddr(ent_raddr),
		.rdata(ent_rdata)
	);

	mcrt_client_ram #(
		.DEPTH(CDEPTH),
		.IDX_W(CIDX_W),
		.BITS (SUBSCRIBE_BITS)
	) u_client_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cl_we),
		.waddr (cl_addr),
		.wbits (cl_wbits),
		.wcount(cl_wcount),
		.raddr (cl_addr),
		.rbits (cl_rbits),
		.rcount(cl_rcount)
	);

endmodule
